@@ rtl/cpme_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package cpme_pkg;

  localparam int VERTICES  = 64;
  localparam int NIDS      = VERTICES + 1;
  localparam int FRESH_ID  = 0;

  typedef logic [5:0] vid_t;
  typedef logic [6:0] cid_t;
  typedef logic [4:0] step_t;

  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_WRITE  = 3'd1;
  localparam logic [2:0] CMD_ASSIGN = 3'd2;
  localparam logic [2:0] CMD_BUILD  = 3'd3;
  localparam logic [2:0] CMD_MOVE   = 3'd4;

  localparam logic [2:0] STS_OK      = 3'd0;
  localparam logic [2:0] STS_BAD_ID  = 3'd1;
  localparam logic [2:0] STS_NO_FREE = 3'd2;
  localparam logic [2:0] STS_UNUSED  = 3'd3;
  localparam logic [2:0] STS_SAME    = 3'd4;

  localparam step_t ST_IDLE = 5'd0;
  localparam step_t ST_DISP = 5'd1;
  localparam step_t ST_CLR  = 5'd2;
  localparam step_t ST_WW0  = 5'd3;
  localparam step_t ST_WW1  = 5'd4;
  localparam step_t ST_AS0  = 5'd5;
  localparam step_t ST_AS1  = 5'd6;
  localparam step_t ST_AS2  = 5'd7;
  localparam step_t ST_MV0  = 5'd8;
  localparam step_t ST_MV1  = 5'd9;
  localparam step_t ST_MV2  = 5'd10;
  localparam step_t ST_MV3  = 5'd11;
  localparam step_t ST_MV4  = 5'd12;
  localparam step_t ST_MV5  = 5'd13;
  localparam step_t ST_MV6  = 5'd14;
  localparam step_t ST_MV7  = 5'd15;
  localparam step_t ST_MV8  = 5'd16;
  localparam step_t ST_MV9  = 5'd17;
  localparam step_t ST_L0   = 5'd18;
  localparam step_t ST_L1   = 5'd19;
  localparam step_t ST_L2   = 5'd20;
  localparam step_t ST_BR0  = 5'd21;
  localparam step_t ST_BC   = 5'd22;
  localparam step_t ST_BJ0  = 5'd23;
  localparam step_t ST_BJ1  = 5'd24;
  localparam step_t ST_BJ2  = 5'd25;
  localparam step_t ST_DONE = 5'd26;

  typedef struct packed {
    step_t step;
    logic  idle;
    logic  accept;
    logic  load_out;
  } ctrl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       as_bad;
    logic       mv_reject;
    logic       i_last;
    logic       j_last;
    logic       c_last;
    logic       out_free;
  } stat_t;

endpackage
`default_nettype wire

@@ rtl/cpme_vtab.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cpme_vtab (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             clr,
  input  wire logic             re,
  input  wire cpme_pkg::cid_t   raddr,
  input  wire logic             we,
  input  wire cpme_pkg::cid_t   waddr,
  input  wire cpme_pkg::cid_t   wdata,
  output cpme_pkg::cid_t        rdata,
  output logic                  rhit,
  output cpme_pkg::cid_t        rid
);

  cpme_pkg::cid_t mem [cpme_pkg::NIDS];
  logic [cpme_pkg::NIDS-1:0] vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
      rhit  <= vld[raddr];
      rid   <= raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/cpme_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cpme_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire cpme_pkg::stat_t st,
  output cpme_pkg::ctrl_t      ctl
);

  cpme_pkg::step_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpme_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cpme_pkg::ST_IDLE: if (in_valid) state_next = cpme_pkg::ST_DISP;
      cpme_pkg::ST_DISP: begin
        case (st.cmd)
          cpme_pkg::CMD_CLEAR:  state_next = cpme_pkg::ST_CLR;
          cpme_pkg::CMD_WRITE:  state_next = cpme_pkg::ST_WW0;
          cpme_pkg::CMD_ASSIGN: state_next = cpme_pkg::ST_AS0;
          cpme_pkg::CMD_BUILD:  state_next = cpme_pkg::ST_BR0;
          cpme_pkg::CMD_MOVE:   state_next = cpme_pkg::ST_MV0;
          default:              state_next = cpme_pkg::ST_DONE;
        endcase
      end
      cpme_pkg::ST_CLR: state_next = cpme_pkg::ST_DONE;
      cpme_pkg::ST_WW0: state_next = cpme_pkg::ST_WW1;
      cpme_pkg::ST_WW1: state_next = cpme_pkg::ST_DONE;
      cpme_pkg::ST_AS0: state_next = st.as_bad ? cpme_pkg::ST_DONE : cpme_pkg::ST_AS1;
      cpme_pkg::ST_AS1: state_next = cpme_pkg::ST_AS2;
      cpme_pkg::ST_AS2: state_next = cpme_pkg::ST_DONE;
      cpme_pkg::ST_MV0: state_next = cpme_pkg::ST_MV1;
      cpme_pkg::ST_MV1: state_next = st.mv_reject ? cpme_pkg::ST_DONE : cpme_pkg::ST_MV2;
      cpme_pkg::ST_MV2: state_next = cpme_pkg::ST_MV3;
      cpme_pkg::ST_MV3: state_next = cpme_pkg::ST_MV4;
      cpme_pkg::ST_MV4: state_next = cpme_pkg::ST_L0;
      cpme_pkg::ST_L0:  state_next = cpme_pkg::ST_L1;
      cpme_pkg::ST_L1:  state_next = cpme_pkg::ST_L2;
      cpme_pkg::ST_L2:  state_next = st.i_last ? cpme_pkg::ST_MV5 : cpme_pkg::ST_L0;
      cpme_pkg::ST_MV5: state_next = cpme_pkg::ST_MV6;
      cpme_pkg::ST_MV6: state_next = cpme_pkg::ST_MV7;
      cpme_pkg::ST_MV7: state_next = cpme_pkg::ST_MV8;
      cpme_pkg::ST_MV8: state_next = cpme_pkg::ST_MV9;
      cpme_pkg::ST_MV9: state_next = cpme_pkg::ST_DONE;
      cpme_pkg::ST_BR0: state_next = cpme_pkg::ST_BC;
      cpme_pkg::ST_BC:  state_next = st.c_last ? cpme_pkg::ST_BJ0 : cpme_pkg::ST_BC;
      cpme_pkg::ST_BJ0: state_next = cpme_pkg::ST_BJ1;
      cpme_pkg::ST_BJ1: state_next = cpme_pkg::ST_BJ2;
      cpme_pkg::ST_BJ2: begin
        if (st.j_last) begin
          state_next = st.i_last ? cpme_pkg::ST_DONE : cpme_pkg::ST_BR0;
        end else begin
          state_next = cpme_pkg::ST_BJ0;
        end
      end
      cpme_pkg::ST_DONE: if (st.out_free) state_next = cpme_pkg::ST_IDLE;
      default: state_next = cpme_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.step     = state;
    ctl.idle     = (state == cpme_pkg::ST_IDLE);
    ctl.accept   = (state == cpme_pkg::ST_IDLE) && in_valid;
    ctl.load_out = (state == cpme_pkg::ST_DONE) && st.out_free;
  end

endmodule
`default_nettype wire

@@ rtl/cpme_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cpme_datapath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cpme_pkg::ctrl_t  ctl,
  output cpme_pkg::stat_t       st,
  input  wire logic [2:0]       in_cmd,
  input  wire cpme_pkg::vid_t   in_vertex,
  input  wire cpme_pkg::vid_t   in_column,
  input  wire cpme_pkg::cid_t   in_cluster,
  input  wire logic [15:0]      in_weight,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [2:0]            out_status,
  output logic [23:0]           out_gain,
  output logic [27:0]           out_objective,
  output cpme_pkg::cid_t        out_target_used,
  output cpme_pkg::cid_t        out_clusters_in_use
);

  localparam cpme_pkg::cid_t MAX_ID = 7'(cpme_pkg::NIDS - 1);
  localparam cpme_pkg::vid_t LAST_V = 6'(cpme_pkg::VERTICES - 1);
  localparam int GDEPTH = cpme_pkg::VERTICES * cpme_pkg::NIDS;
  localparam int WDEPTH = cpme_pkg::VERTICES * cpme_pkg::VERTICES;

  function automatic cpme_pkg::cid_t cid(input cpme_pkg::cid_t x);
    cid = (x > MAX_ID) ? 7'(cpme_pkg::FRESH_ID) : x;
  endfunction

  function automatic logic [12:0] gaddr(input cpme_pkg::vid_t v, input cpme_pkg::cid_t c);
    gaddr = {1'b0, v, 6'b0} + {7'b0, v} + {6'b0, c};
  endfunction

  logic [2:0]           q_cmd;
  cpme_pkg::vid_t       q_v, q_col;
  cpme_pkg::cid_t       q_cl;
  logic [15:0]          q_w;
  cpme_pkg::cid_t       ss;
  logic [27:0]          obj;
  cpme_pkg::cid_t       old_c, tgt, vc_i, vcj, used;
  logic [22:0]          gt;
  logic [23:0]          gain;
  logic [2:0]           res_status;
  logic                 grow, zero_old, rel;
  cpme_pkg::vid_t       i, j;
  cpme_pkg::cid_t       c;

  logic [15:0]          wmem [WDEPTH];
  logic [15:0]          w_rd;
  logic                 w_re, w_we;
  logic [11:0]          w_raddr, w_waddr;

  logic [22:0]          gmem [GDEPTH];
  logic [22:0]          g_rd, g_wdata;
  logic                 g_re, g_we;
  logic [12:0]          g_raddr, g_waddr;

  cpme_pkg::cid_t       vcmem [cpme_pkg::VERTICES];
  cpme_pkg::cid_t       vc_rd, vc_wdata;
  logic                 vc_re, vc_we;
  cpme_pkg::vid_t       vc_raddr, vc_waddr;

  logic                 tab_clr;
  logic                 cnt_re, cnt_we, pos_re, pos_we, lst_re, lst_we;
  cpme_pkg::cid_t       cnt_raddr, cnt_waddr, cnt_wdata;
  cpme_pkg::cid_t       pos_raddr, pos_waddr, pos_wdata;
  cpme_pkg::cid_t       lst_raddr, lst_waddr, lst_wdata;
  cpme_pkg::cid_t       cnt_raw, pos_raw, lst_raw, cnt_id, pos_id, lst_id;
  logic                 cnt_hit, pos_hit, lst_hit;
  cpme_pkg::cid_t       cnt_val, pos_val, lst_val, cnt_dec;
  logic [22:0]          w_ext;
  logic [2:0]           rej_code;
  logic                 as_bad, rel_now;

  cpme_vtab u_cnt (
    .clk(clk), .rst(rst), .clr(tab_clr),
    .re(cnt_re), .raddr(cnt_raddr), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .rdata(cnt_raw), .rhit(cnt_hit), .rid(cnt_id)
  );

  cpme_vtab u_pos (
    .clk(clk), .rst(rst), .clr(tab_clr),
    .re(pos_re), .raddr(pos_raddr), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .rdata(pos_raw), .rhit(pos_hit), .rid(pos_id)
  );

  cpme_vtab u_lst (
    .clk(clk), .rst(rst), .clr(tab_clr),
    .re(lst_re), .raddr(lst_raddr), .we(lst_we), .waddr(lst_waddr), .wdata(lst_wdata),
    .rdata(lst_raw), .rhit(lst_hit), .rid(lst_id)
  );

  always_ff @(posedge clk) begin
    if (w_we) wmem[w_waddr] <= q_w;
    if (w_re) w_rd <= wmem[w_raddr];
    if (g_we) gmem[g_waddr] <= g_wdata;
    if (g_re) g_rd <= gmem[g_raddr];
    if (vc_we) vcmem[vc_waddr] <= vc_wdata;
    if (vc_re) vc_rd <= vcmem[vc_raddr];
  end

  always_comb begin
    cnt_val = cnt_hit ? cnt_raw : '0;
    pos_val = pos_hit ? pos_raw : pos_id;
    lst_val = lst_hit ? lst_raw : lst_id;
    cnt_dec = (cnt_val != '0) ? cnt_val - 7'd1 : '0;
    w_ext   = {{7{w_rd[15]}}, w_rd};
    as_bad  = (q_cl == 7'(cpme_pkg::FRESH_ID)) || (q_cl > MAX_ID);
    rel_now = zero_old && (old_c != 7'(cpme_pkg::FRESH_ID)) && (pos_val < ss);
    if (q_cl > MAX_ID) begin
      rej_code = cpme_pkg::STS_BAD_ID;
    end else if ((q_cl != 7'(cpme_pkg::FRESH_ID)) && (pos_val >= ss)) begin
      rej_code = cpme_pkg::STS_UNUSED;
    end else if (q_cl == vc_rd) begin
      rej_code = cpme_pkg::STS_SAME;
    end else if ((q_cl == 7'(cpme_pkg::FRESH_ID)) && (ss > MAX_ID)) begin
      rej_code = cpme_pkg::STS_NO_FREE;
    end else begin
      rej_code = cpme_pkg::STS_OK;
    end
  end

  always_comb begin
    w_re = 1'b0; w_raddr = {q_v, i}; w_we = 1'b0; w_waddr = {q_v, q_col};
    g_re = 1'b0; g_raddr = '0; g_we = 1'b0; g_waddr = '0; g_wdata = '0;
    vc_re = 1'b0; vc_raddr = q_v; vc_we = 1'b0; vc_waddr = q_v; vc_wdata = q_cl;
    cnt_re = 1'b0; cnt_raddr = '0; cnt_we = 1'b0; cnt_waddr = '0; cnt_wdata = '0;
    pos_re = 1'b0; pos_raddr = '0; pos_we = 1'b0; pos_waddr = '0; pos_wdata = '0;
    lst_re = 1'b0; lst_raddr = '0; lst_we = 1'b0; lst_waddr = '0; lst_wdata = '0;
    tab_clr = (ctl.step == cpme_pkg::ST_CLR);
    case (ctl.step)
      cpme_pkg::ST_WW0: begin
        w_we = 1'b1; w_waddr = {q_v, q_col};
      end
      cpme_pkg::ST_WW1: begin
        w_we = 1'b1; w_waddr = {q_col, q_v};
      end
      cpme_pkg::ST_AS0: begin
        pos_re = 1'b1; pos_raddr = cid(q_cl);
        lst_re = 1'b1; lst_raddr = cid(ss);
        cnt_re = 1'b1; cnt_raddr = cid(q_cl);
      end
      cpme_pkg::ST_AS1: begin
        if (pos_val >= ss) begin
          lst_we = 1'b1; lst_waddr = cid(pos_val); lst_wdata = lst_val;
          pos_we = 1'b1; pos_waddr = cid(lst_val); pos_wdata = pos_val;
        end
        cnt_we = 1'b1; cnt_waddr = cid(q_cl); cnt_wdata = cnt_val + 7'd1;
        vc_we = 1'b1; vc_wdata = q_cl;
      end
      cpme_pkg::ST_AS2: begin
        if (grow) begin
          lst_we = 1'b1; lst_waddr = cid(ss); lst_wdata = q_cl;
          pos_we = 1'b1; pos_waddr = cid(q_cl); pos_wdata = ss;
        end
      end
      cpme_pkg::ST_MV0: begin
        pos_re = 1'b1; pos_raddr = cid(q_cl);
        lst_re = 1'b1; lst_raddr = cid(ss);
        vc_re = 1'b1;
      end
      cpme_pkg::ST_MV2: begin
        g_re = 1'b1; g_raddr = gaddr(q_v, tgt);
      end
      cpme_pkg::ST_MV3: begin
        g_re = 1'b1; g_raddr = gaddr(q_v, old_c);
      end
      cpme_pkg::ST_L0: begin
        w_re = 1'b1; w_raddr = {q_v, i};
        g_re = 1'b1; g_raddr = gaddr(i, old_c);
      end
      cpme_pkg::ST_L1: begin
        g_we = (i != q_v) && (old_c != tgt); g_waddr = gaddr(i, old_c); g_wdata = g_rd - w_ext;
        g_re = 1'b1; g_raddr = gaddr(i, tgt);
      end
      cpme_pkg::ST_L2: begin
        g_we = (i != q_v) && (old_c != tgt); g_waddr = gaddr(i, tgt); g_wdata = g_rd + w_ext;
      end
      cpme_pkg::ST_MV5: begin
        cnt_re = 1'b1; cnt_raddr = cid(old_c);
      end
      cpme_pkg::ST_MV6: begin
        cnt_we = 1'b1; cnt_waddr = cid(old_c); cnt_wdata = cnt_dec;
        cnt_re = 1'b1; cnt_raddr = cid(tgt);
      end
      cpme_pkg::ST_MV7: begin
        cnt_we = 1'b1; cnt_waddr = cid(tgt);
        cnt_wdata = (tgt == old_c) ? cnt_dec + 7'd1 : cnt_val + 7'd1;
        pos_re = 1'b1; pos_raddr = cid(old_c);
        lst_re = 1'b1; lst_raddr = cid(ss - 7'd1);
        vc_we = 1'b1; vc_wdata = tgt;
      end
      cpme_pkg::ST_MV8: begin
        if (rel_now) begin
          lst_we = 1'b1; lst_waddr = cid(pos_val); lst_wdata = lst_val;
          pos_we = 1'b1; pos_waddr = cid(lst_val); pos_wdata = pos_val;
        end
      end
      cpme_pkg::ST_MV9: begin
        if (rel) begin
          lst_we = 1'b1; lst_waddr = cid(ss - 7'd1); lst_wdata = old_c;
          pos_we = 1'b1; pos_waddr = cid(old_c); pos_wdata = ss - 7'd1;
        end
      end
      cpme_pkg::ST_BR0: begin
        vc_re = 1'b1; vc_raddr = i;
      end
      cpme_pkg::ST_BC: begin
        g_we = 1'b1; g_waddr = gaddr(i, c); g_wdata = '0;
      end
      cpme_pkg::ST_BJ0: begin
        vc_re = 1'b1; vc_raddr = j;
        w_re = 1'b1; w_raddr = {i, j};
      end
      cpme_pkg::ST_BJ1: begin
        g_re = 1'b1; g_raddr = gaddr(i, cid(vc_rd));
      end
      cpme_pkg::ST_BJ2: begin
        g_we = (j != i); g_waddr = gaddr(i, vcj); g_wdata = g_rd + w_ext;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ss  <= 7'd1;
      obj <= '0;
    end else begin
      case (ctl.step)
        cpme_pkg::ST_DISP: if (q_cmd == cpme_pkg::CMD_BUILD) obj <= '0;
        cpme_pkg::ST_CLR: begin
          ss  <= 7'd1;
          obj <= '0;
        end
        cpme_pkg::ST_AS2: if (grow) ss <= ss + 7'd1;
        cpme_pkg::ST_MV1: begin
          if (rej_code == cpme_pkg::STS_OK && q_cl == 7'(cpme_pkg::FRESH_ID)) begin
            ss <= ss + 7'd1;
          end
        end
        cpme_pkg::ST_MV7: obj <= obj + {{4{gain[23]}}, gain};
        cpme_pkg::ST_MV9: if (rel) ss <= ss - 7'd1;
        cpme_pkg::ST_BJ1: begin
          if (j >= i && vc_rd == vc_i) obj <= obj + {{12{w_rd[15]}}, w_rd};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      q_cmd      <= in_cmd;
      q_v        <= in_vertex;
      q_col      <= in_column;
      q_cl       <= in_cluster;
      q_w        <= in_weight;
      res_status <= cpme_pkg::STS_OK;
      gain       <= '0;
      used       <= '0;
      i          <= '0;
    end
    case (ctl.step)
      cpme_pkg::ST_AS0: if (as_bad) res_status <= cpme_pkg::STS_BAD_ID;
      cpme_pkg::ST_AS1: grow <= (pos_val >= ss);
      cpme_pkg::ST_MV1: begin
        old_c <= vc_rd;
        res_status <= rej_code;
        tgt <= (q_cl == 7'(cpme_pkg::FRESH_ID)) ? lst_val : q_cl;
      end
      cpme_pkg::ST_MV3: gt <= g_rd;
      cpme_pkg::ST_MV4: gain <= {gt[22], gt} - {g_rd[22], g_rd};
      cpme_pkg::ST_L2:  i <= i + 6'd1;
      cpme_pkg::ST_MV6: zero_old <= (cnt_dec == '0) && (old_c != tgt);
      cpme_pkg::ST_MV7: used <= tgt;
      cpme_pkg::ST_MV8: rel <= rel_now;
      cpme_pkg::ST_BR0: begin
        c <= '0;
        j <= '0;
      end
      cpme_pkg::ST_BC: begin
        c <= c + 7'd1;
        if (c == '0) vc_i <= vc_rd;
      end
      cpme_pkg::ST_BJ1: vcj <= cid(vc_rd);
      cpme_pkg::ST_BJ2: begin
        j <= j + 6'd1;
        if (j == LAST_V) i <= i + 6'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_status          <= res_status;
      out_gain            <= gain;
      out_objective       <= obj;
      out_target_used     <= used;
      out_clusters_in_use <= ss;
    end
  end

  always_comb begin
    st.cmd       = q_cmd;
    st.as_bad    = as_bad;
    st.mv_reject = (rej_code != cpme_pkg::STS_OK);
    st.i_last    = (i == LAST_V);
    st.j_last    = (j == LAST_V);
    st.c_last    = (c == MAX_ID);
    st.out_free  = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

@@ rtl/clique_partition_move_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One item at a time; an item is taken in the idle state, in the cycle after the last result loads.
// Commands: clear, weight write, assign (ends early on a bad id), move (ends early when
// rejected, else walks every vertex on the single-port gain table), and build.
// A result held by the receiver stalls the block in its final state.
// Reset clears the controller, set size, objective and the valid bits of the count and
// set tables at once; weights, gain table and vertex clusters hold until written.
module clique_partition_move_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // cmd[2:0], vertex[8:3], column[14:9], cluster[21:15], weight[37:22]
  input  wire logic [39:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[2:0], gain[26:3], objective[54:27], target_used[61:55], clusters_in_use[68:62]
  output logic [71:0]      m_axis_tdata
);

  cpme_pkg::ctrl_t ctl;
  cpme_pkg::stat_t st;
  logic [2:0]      o_status;
  logic [23:0]     o_gain;
  logic [27:0]     o_obj;
  cpme_pkg::cid_t  o_used, o_ss;

  cpme_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .st(st), .ctl(ctl)
  );

  cpme_datapath u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .st(st),
    .in_cmd(s_axis_tdata[2:0]),
    .in_vertex(s_axis_tdata[8:3]),
    .in_column(s_axis_tdata[14:9]),
    .in_cluster(s_axis_tdata[21:15]),
    .in_weight(s_axis_tdata[37:22]),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_status(o_status),
    .out_gain(o_gain),
    .out_objective(o_obj),
    .out_target_used(o_used),
    .out_clusters_in_use(o_ss)
  );

  assign s_axis_tready = ctl.idle;
  assign m_axis_tdata  = {3'b0, o_ss, o_used, o_obj, o_gain, o_status};

endmodule
`default_nettype wire
